[src/sitoa_pkg.sv]
// Shared constants and control types for the signed integer to decimal text unit.
package sitoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PROD_W     = 2 * VALUE_W;

  // Division by ten as multiplication by ceil(2^35 / 10), then a shift right by 35.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        QUO_W       = PROD_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic load;        // capture a new value
    logic step;        // peel off one digit
    logic emit_sign;   // put '-' into the output register
    logic emit_digit;  // put the next digit into the output register
  } sitoa_cmd_t;

  typedef struct packed {
    logic quo_zero;    // quotient of the current divide step is zero
    logic negative;    // captured value is negative
    logic out_free;    // output register can take a character this cycle
    logic last_digit;  // one digit is left to send
  } sitoa_status_t;

endpackage

[src/signed_int_to_decimal_ascii_unit.sv]
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+--------------------------
//   in      | input     | in_valid / in_stall | value (32-bit signed)
//   out     | output    | out_valid/out_stall | character (8 bits), last
//
// Each input beat is captured, then its decimal digits (1 to 10) are extracted
// one per cycle by the single divide-by-ten unit, then its characters (1 to 11)
// are sent one per cycle while the output is not stalled. A stall that holds
// back a waiting sign or digit delays the value; a stall on the final character
// is hidden while the next value is captured and its digits extracted.
// Synchronous reset returns the unit to idle, output empty.
module signed_int_to_decimal_ascii_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sitoa_pkg::CHAR_W-1:0]        character,
  output logic                                last
);
  import sitoa_pkg::*;

  sitoa_cmd_t    cmd;
  sitoa_status_t status;

  // The controller walks idle, divide, sign and digit phases.
  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath peels digits least significant first into a small store,
  // then reads them back most significant first into the output register.
  sitoa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  // Every character sent is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  ((character >= CHAR_ZERO) && (character <= CHAR_NINE)))
    else $error("character outside the decimal text alphabet");

  // The text never ends on a minus sign.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (character != CHAR_MINUS))
    else $error("minus sign flagged as last character");

  // After a value is taken the unit is busy until its digits are out.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again without converting the previous value");

  // A character is loaded only when the output register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
    else $error("output register overwritten while stalled");

endmodule

[src/sitoa_dp.sv]
// Datapath: magnitude register, divide-by-ten step, digit store and output register.
module sitoa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
  input  sitoa_pkg::sitoa_cmd_t               cmd,
  output sitoa_pkg::sitoa_status_t            status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sitoa_pkg::CHAR_W-1:0]        character,
  output logic                                last
);
  import sitoa_pkg::*;

  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_in;
  logic [VALUE_W-1:0] mag;
  logic               negative;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] quo_times_ten;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_dec;

  assign raw    = $unsigned(value);
  // The most negative value wraps to 2^31, which is its true magnitude.
  assign mag_in = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  assign prod          = {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quo           = {{(VALUE_W-QUO_W){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
  assign quo_times_ten = {quo[VALUE_W-4:0], 3'b000} + {quo[VALUE_W-2:0], 1'b0};
  assign rem           = mag[DIGIT_W-1:0] - quo_times_ten[DIGIT_W-1:0];
  assign cnt_dec       = cnt - CNT_W'(1);

  assign status.quo_zero   = (quo == '0);
  assign status.negative   = negative;
  assign status.out_free   = !out_valid || !out_stall;
  assign status.last_digit = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.emit_digit) begin
        cnt <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_in;
      negative <= raw[VALUE_W-1];
    end else if (cmd.step) begin
      mag         <= quo;
      digits[cnt] <= rem;
    end
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[cnt_dec]};
      last      <= (cnt == CNT_W'(1));
    end
  end

endmodule

[src/sitoa_ctrl.sv]
// Controller: sequences capture, digit extraction and character emission.
module sitoa_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sitoa_pkg::sitoa_status_t status,
  output sitoa_pkg::sitoa_cmd_t    cmd
);
  import sitoa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_SIGN,
    S_DIGITS
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load       = in_valid;
      S_DIVIDE: cmd.step       = 1'b1;
      S_SIGN:   cmd.emit_sign  = status.out_free;
      S_DIGITS: cmd.emit_digit = status.out_free;
      default:  cmd            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (status.quo_zero) begin
            state <= status.negative ? S_SIGN : S_DIGITS;
          end
        end
        S_SIGN: begin
          if (status.out_free) begin
            state <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (status.out_free && status.last_digit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
